>>> rtl/core/segx_pkg.sv
// Shared constants and helpers for the segment intersection pipeline.
package segx_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Open-box rule: strict on both axes, or on one axis when the box is flat on the other
  function automatic logic box_rule(input logic inx, input logic iny,
                                    input logic flat_x, input logic flat_y);
    return (flat_x && iny) || (flat_y && inx) || (inx && iny);
  endfunction

endpackage

>>> rtl/core/segx_in_if.sv
// Input channel: one beat carries both segments.
interface segx_in_if
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

>>> rtl/core/segx_out_if.sv
// Output channel: one beat carries the intersection flag.
interface segx_out_if ();
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink (input valid, intersects, output ready);
endinterface

>>> rtl/core/segx_coef.sv
// Stage 1: line coefficients of both segments.
module segx_coef
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   ax0,
  input  logic signed [COORD_BITS-1:0]   ay0,
  input  logic signed [COORD_BITS-1:0]   ax1,
  input  logic signed [COORD_BITS-1:0]   ay1,
  input  logic signed [COORD_BITS-1:0]   bx0,
  input  logic signed [COORD_BITS-1:0]   by0,
  input  logic signed [COORD_BITS-1:0]   bx1,
  input  logic signed [COORD_BITS-1:0]   by1,
  output logic                           v1,
  output logic signed [COORD_BITS-1:0]   s1_ax0,
  output logic signed [COORD_BITS-1:0]   s1_ay0,
  output logic signed [COORD_BITS-1:0]   s1_ax1,
  output logic signed [COORD_BITS-1:0]   s1_ay1,
  output logic signed [COORD_BITS-1:0]   s1_bx0,
  output logic signed [COORD_BITS-1:0]   s1_by0,
  output logic signed [COORD_BITS-1:0]   s1_bx1,
  output logic signed [COORD_BITS-1:0]   s1_by1,
  output logic signed [COORD_BITS:0]     pa,
  output logic signed [COORD_BITS:0]     qa,
  output logic signed [COORD_BITS:0]     pb,
  output logic signed [COORD_BITS:0]     qb,
  output logic signed [2*COORD_BITS:0]   ra,
  output logic signed [2*COORD_BITS:0]   rb
);
  localparam int N  = COORD_BITS;
  localparam int DW = N + 1;
  localparam int RW = 2 * N + 1;
  localparam int MW = 2 * N;

  logic signed [2*N-1:0] ma0, ma1, mb0, mb1;

  // Constant terms: y1*x0 - y0*x1
  assign ma0 = MW'(ay1) * MW'(ax0);
  assign ma1 = MW'(ay0) * MW'(ax1);
  assign mb0 = MW'(by1) * MW'(bx0);
  assign mb1 = MW'(by0) * MW'(bx1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax0 <= ax0;
      s1_ay0 <= ay0;
      s1_ax1 <= ax1;
      s1_ay1 <= ay1;
      s1_bx0 <= bx0;
      s1_by0 <= by0;
      s1_bx1 <= bx1;
      s1_by1 <= by1;
      pa     <= DW'(ay0) - DW'(ay1);
      qa     <= DW'(ax1) - DW'(ax0);
      pb     <= DW'(by0) - DW'(by1);
      qb     <= DW'(bx1) - DW'(bx0);
      ra     <= RW'(ma0) - RW'(ma1);
      rb     <= RW'(mb0) - RW'(mb1);
    end
  end
endmodule

>>> rtl/core/segx_cross.sv
// Stage 2: determinant, crossing numerators, side tests, lengths and boxes.
module segx_cross
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           v1,
  input  logic signed [COORD_BITS-1:0]   ax0,
  input  logic signed [COORD_BITS-1:0]   ay0,
  input  logic signed [COORD_BITS-1:0]   ax1,
  input  logic signed [COORD_BITS-1:0]   ay1,
  input  logic signed [COORD_BITS-1:0]   bx0,
  input  logic signed [COORD_BITS-1:0]   by0,
  input  logic signed [COORD_BITS-1:0]   bx1,
  input  logic signed [COORD_BITS-1:0]   by1,
  input  logic signed [COORD_BITS:0]     pa,
  input  logic signed [COORD_BITS:0]     qa,
  input  logic signed [COORD_BITS:0]     pb,
  input  logic signed [COORD_BITS:0]     qb,
  input  logic signed [2*COORD_BITS:0]   ra,
  input  logic signed [2*COORD_BITS:0]   rb,
  output logic                           v2,
  output logic signed [2*COORD_BITS+2:0] det,
  output logic signed [3*COORD_BITS+2:0] num_x,
  output logic signed [3*COORD_BITS+2:0] num_y,
  output logic signed [2*COORD_BITS+2:0] side_a,
  output logic signed [2*COORD_BITS+2:0] side_b,
  output logic signed [2*COORD_BITS+2:0] len_a,
  output logic signed [2*COORD_BITS+2:0] len_b,
  output logic signed [COORD_BITS-1:0]   s2_ax0,
  output logic signed [COORD_BITS-1:0]   s2_ay0,
  output logic signed [COORD_BITS-1:0]   s2_ax1,
  output logic signed [COORD_BITS-1:0]   s2_ay1,
  output logic signed [COORD_BITS-1:0]   s2_bx0,
  output logic signed [COORD_BITS-1:0]   s2_by0,
  output logic signed [COORD_BITS-1:0]   s2_bx1,
  output logic signed [COORD_BITS-1:0]   s2_by1,
  output logic signed [COORD_BITS-1:0]   mnx_a,
  output logic signed [COORD_BITS-1:0]   mxx_a,
  output logic signed [COORD_BITS-1:0]   mny_a,
  output logic signed [COORD_BITS-1:0]   mxy_a,
  output logic signed [COORD_BITS-1:0]   mnx_b,
  output logic signed [COORD_BITS-1:0]   mxx_b,
  output logic signed [COORD_BITS-1:0]   mny_b,
  output logic signed [COORD_BITS-1:0]   mxy_b
);
  localparam int N   = COORD_BITS;
  localparam int TW  = 2 * N + 3;
  localparam int PW  = 3 * N + 3;
  localparam int DPW = 2 * N + 2;
  localparam int XPW = 3 * N + 2;
  localparam int SPW = 2 * N + 1;

  logic signed [2*N+1:0] d0, d1;
  logic signed [3*N+1:0] y0m, y1m, x0m, x1m;
  logic signed [2*N:0]   sa0, sa1, sb0, sb1;
  logic signed [2*N+1:0] qa2, pa2, qb2, pb2;

  // Determinant of the two line equations
  assign d0 = DPW'(pb) * DPW'(qa);
  assign d1 = DPW'(pa) * DPW'(qb);

  // Crossing point numerators
  assign y0m = XPW'(pa) * XPW'(rb);
  assign y1m = XPW'(pb) * XPW'(ra);
  assign x0m = XPW'(qb) * XPW'(ra);
  assign x1m = XPW'(qa) * XPW'(rb);

  // Start of A against line B, start of B against line A
  assign sa0 = SPW'(pb) * SPW'(ax0);
  assign sa1 = SPW'(qb) * SPW'(ay0);
  assign sb0 = SPW'(pa) * SPW'(bx0);
  assign sb1 = SPW'(qa) * SPW'(by0);

  // Squared lengths
  assign qa2 = DPW'(qa) * DPW'(qa);
  assign pa2 = DPW'(pa) * DPW'(pa);
  assign qb2 = DPW'(qb) * DPW'(qb);
  assign pb2 = DPW'(pb) * DPW'(pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det    <= TW'(d0) - TW'(d1);
      num_y  <= PW'(y0m) - PW'(y1m);
      num_x  <= PW'(x0m) - PW'(x1m);
      side_a <= TW'(sa0) + TW'(sa1) + TW'(rb);
      side_b <= TW'(sb0) + TW'(sb1) + TW'(ra);
      len_a  <= TW'(qa2) + TW'(pa2);
      len_b  <= TW'(qb2) + TW'(pb2);
      s2_ax0 <= ax0;
      s2_ay0 <= ay0;
      s2_ax1 <= ax1;
      s2_ay1 <= ay1;
      s2_bx0 <= bx0;
      s2_by0 <= by0;
      s2_bx1 <= bx1;
      s2_by1 <= by1;
      mnx_a  <= (ax0 < ax1) ? ax0 : ax1;
      mxx_a  <= (ax0 > ax1) ? ax0 : ax1;
      mny_a  <= (ay0 < ay1) ? ay0 : ay1;
      mxy_a  <= (ay0 > ay1) ? ay0 : ay1;
      mnx_b  <= (bx0 < bx1) ? bx0 : bx1;
      mxx_b  <= (bx0 > bx1) ? bx0 : bx1;
      mny_b  <= (by0 < by1) ? by0 : by1;
      mxy_b  <= (by0 > by1) ? by0 : by1;
    end
  end
endmodule

>>> rtl/core/segx_bound.sv
// Stage 3: box bounds scaled by the determinant, and the collinear overlap verdict.
module segx_bound
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           v2,
  input  logic signed [2*COORD_BITS+2:0] det,
  input  logic signed [3*COORD_BITS+2:0] num_x,
  input  logic signed [3*COORD_BITS+2:0] num_y,
  input  logic signed [2*COORD_BITS+2:0] side_a,
  input  logic signed [2*COORD_BITS+2:0] side_b,
  input  logic signed [2*COORD_BITS+2:0] len_a,
  input  logic signed [2*COORD_BITS+2:0] len_b,
  input  logic signed [COORD_BITS-1:0]   ax0,
  input  logic signed [COORD_BITS-1:0]   ay0,
  input  logic signed [COORD_BITS-1:0]   ax1,
  input  logic signed [COORD_BITS-1:0]   ay1,
  input  logic signed [COORD_BITS-1:0]   bx0,
  input  logic signed [COORD_BITS-1:0]   by0,
  input  logic signed [COORD_BITS-1:0]   bx1,
  input  logic signed [COORD_BITS-1:0]   by1,
  input  logic signed [COORD_BITS-1:0]   mnx_a,
  input  logic signed [COORD_BITS-1:0]   mxx_a,
  input  logic signed [COORD_BITS-1:0]   mny_a,
  input  logic signed [COORD_BITS-1:0]   mxy_a,
  input  logic signed [COORD_BITS-1:0]   mnx_b,
  input  logic signed [COORD_BITS-1:0]   mxx_b,
  input  logic signed [COORD_BITS-1:0]   mny_b,
  input  logic signed [COORD_BITS-1:0]   mxy_b,
  output logic                           v3,
  output logic signed [3*COORD_BITS+2:0] s3_x,
  output logic signed [3*COORD_BITS+2:0] s3_y,
  output logic signed [3*COORD_BITS+2:0] lox_a,
  output logic signed [3*COORD_BITS+2:0] hix_a,
  output logic signed [3*COORD_BITS+2:0] loy_a,
  output logic signed [3*COORD_BITS+2:0] hiy_a,
  output logic signed [3*COORD_BITS+2:0] lox_b,
  output logic signed [3*COORD_BITS+2:0] hix_b,
  output logic signed [3*COORD_BITS+2:0] loy_b,
  output logic signed [3*COORD_BITS+2:0] hiy_b,
  output logic                           flat_xa,
  output logic                           flat_ya,
  output logic                           flat_xb,
  output logic                           flat_yb,
  output logic                           crossing,
  output logic                           col_hit
);
  localparam int N  = COORD_BITS;
  localparam int BW = 3 * N + 3;

  logic                  neg;
  logic signed [N-1:0]   sel_lox_a, sel_hix_a, sel_loy_a, sel_hiy_a;
  logic signed [N-1:0]   sel_lox_b, sel_hix_b, sel_loy_b, sel_hiy_b;
  logic                  a_shorter;
  logic                  colinear;
  logic signed [N-1:0]   p0x, p0y, p1x, p1y;
  logic signed [N-1:0]   bmnx, bmxx, bmny, bmxy;
  logic                  p0_in, p1_in, bflat_x, bflat_y;

  // A negative determinant swaps the scaled bounds
  assign neg       = det[2*N+2];
  assign sel_lox_a = neg ? mxx_a : mnx_a;
  assign sel_hix_a = neg ? mnx_a : mxx_a;
  assign sel_loy_a = neg ? mxy_a : mny_a;
  assign sel_hiy_a = neg ? mny_a : mxy_a;
  assign sel_lox_b = neg ? mxx_b : mnx_b;
  assign sel_hix_b = neg ? mnx_b : mxx_b;
  assign sel_loy_b = neg ? mxy_b : mny_b;
  assign sel_hiy_b = neg ? mny_b : mxy_b;

  // Collinear case: endpoints of the shorter segment against the longer one's box
  assign colinear  = (side_a == '0) && (side_b == '0);
  assign a_shorter = len_a < len_b;
  assign p0x  = a_shorter ? ax0 : bx0;
  assign p0y  = a_shorter ? ay0 : by0;
  assign p1x  = a_shorter ? ax1 : bx1;
  assign p1y  = a_shorter ? ay1 : by1;
  assign bmnx = a_shorter ? mnx_b : mnx_a;
  assign bmxx = a_shorter ? mxx_b : mxx_a;
  assign bmny = a_shorter ? mny_b : mny_a;
  assign bmxy = a_shorter ? mxy_b : mxy_a;
  assign bflat_x = (bmnx == bmxx);
  assign bflat_y = (bmny == bmxy);
  assign p0_in = box_rule((p0x > bmnx) && (p0x < bmxx), (p0y > bmny) && (p0y < bmxy),
                          bflat_x, bflat_y);
  assign p1_in = box_rule((p1x > bmnx) && (p1x < bmxx), (p1y > bmny) && (p1y < bmxy),
                          bflat_x, bflat_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x     <= num_x;
      s3_y     <= num_y;
      lox_a    <= BW'(det) * BW'(sel_lox_a);
      hix_a    <= BW'(det) * BW'(sel_hix_a);
      loy_a    <= BW'(det) * BW'(sel_loy_a);
      hiy_a    <= BW'(det) * BW'(sel_hiy_a);
      lox_b    <= BW'(det) * BW'(sel_lox_b);
      hix_b    <= BW'(det) * BW'(sel_hix_b);
      loy_b    <= BW'(det) * BW'(sel_loy_b);
      hiy_b    <= BW'(det) * BW'(sel_hiy_b);
      flat_xa  <= (mnx_a == mxx_a);
      flat_ya  <= (mny_a == mxy_a);
      flat_xb  <= (mnx_b == mxx_b);
      flat_yb  <= (mny_b == mxy_b);
      crossing <= (det != '0);
      col_hit  <= colinear && (p0_in || p1_in);
    end
  end
endmodule

>>> rtl/core/segx_decide.sv
// Stage 4: crossing point against both boxes; output register.
module segx_decide
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           v3,
  input  logic signed [3*COORD_BITS+2:0] num_x,
  input  logic signed [3*COORD_BITS+2:0] num_y,
  input  logic signed [3*COORD_BITS+2:0] lox_a,
  input  logic signed [3*COORD_BITS+2:0] hix_a,
  input  logic signed [3*COORD_BITS+2:0] loy_a,
  input  logic signed [3*COORD_BITS+2:0] hiy_a,
  input  logic signed [3*COORD_BITS+2:0] lox_b,
  input  logic signed [3*COORD_BITS+2:0] hix_b,
  input  logic signed [3*COORD_BITS+2:0] loy_b,
  input  logic signed [3*COORD_BITS+2:0] hiy_b,
  input  logic                           flat_xa,
  input  logic                           flat_ya,
  input  logic                           flat_xb,
  input  logic                           flat_yb,
  input  logic                           crossing,
  input  logic                           col_hit,
  output logic                           v4,
  output logic                           hit
);
  logic in_a, in_b, hit_next;

  // Strict inside tests on the scaled bounds
  assign in_a = box_rule((num_x > lox_a) && (num_x < hix_a),
                         (num_y > loy_a) && (num_y < hiy_a), flat_xa, flat_ya);
  assign in_b = box_rule((num_x > lox_b) && (num_x < hix_b),
                         (num_y > loy_b) && (num_y < hiy_b), flat_xb, flat_yb);
  assign hit_next = crossing ? (in_a && in_b) : col_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= hit_next;
    end
  end
endmodule

>>> rtl/core/segment_intersection_test.sv
// Pipeline: four registered stages lie between an accepted input beat and its result beat.
// Throughput: one segment pair per cycle; the four stages shift together, so output
//   backpressure holds the whole pipeline and input ready follows the output register.
// Reset: synchronous rst clears the stage valid bits; no other state, no clearing pass.
// Stages: coefficients, cross products, scaled bounds, box compares with output register.
module segment_intersection_test
  import segx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  segx_in_if.sink    segs,
  segx_out_if.source res
);
  localparam int N = COORD_BITS;

  logic adv;
  logic v1, v2, v3, v4;

  logic signed [N-1:0]   c1_ax0, c1_ay0, c1_ax1, c1_ay1, c1_bx0, c1_by0, c1_bx1, c1_by1;
  logic signed [N:0]     pa, qa, pb, qb;
  logic signed [2*N:0]   ra, rb;

  logic signed [2*N+2:0] det, side_a, side_b, len_a, len_b;
  logic signed [3*N+2:0] num_x, num_y;
  logic signed [N-1:0]   c2_ax0, c2_ay0, c2_ax1, c2_ay1, c2_bx0, c2_by0, c2_bx1, c2_by1;
  logic signed [N-1:0]   mnx_a, mxx_a, mny_a, mxy_a, mnx_b, mxx_b, mny_b, mxy_b;

  logic signed [3*N+2:0] s3_x, s3_y;
  logic signed [3*N+2:0] lox_a, hix_a, loy_a, hiy_a, lox_b, hix_b, loy_b, hiy_b;
  logic                  flat_xa, flat_ya, flat_xb, flat_yb, crossing, col_hit;
  logic                  hit;

  // Pipeline moves when the output register is empty or being drained
  assign adv          = !v4 || res.ready;
  assign segs.ready   = adv;
  assign res.valid    = v4;
  assign res.intersects = hit;

  segx_coef #(.COORD_BITS(COORD_BITS)) u_coef (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(segs.valid),
    .ax0(segs.a_start_x), .ay0(segs.a_start_y), .ax1(segs.a_end_x), .ay1(segs.a_end_y),
    .bx0(segs.b_start_x), .by0(segs.b_start_y), .bx1(segs.b_end_x), .by1(segs.b_end_y),
    .v1(v1),
    .s1_ax0(c1_ax0), .s1_ay0(c1_ay0), .s1_ax1(c1_ax1), .s1_ay1(c1_ay1),
    .s1_bx0(c1_bx0), .s1_by0(c1_by0), .s1_bx1(c1_bx1), .s1_by1(c1_by1),
    .pa(pa), .qa(qa), .pb(pb), .qb(qb), .ra(ra), .rb(rb)
  );

  segx_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .rst(rst), .adv(adv), .v1(v1),
    .ax0(c1_ax0), .ay0(c1_ay0), .ax1(c1_ax1), .ay1(c1_ay1),
    .bx0(c1_bx0), .by0(c1_by0), .bx1(c1_bx1), .by1(c1_by1),
    .pa(pa), .qa(qa), .pb(pb), .qb(qb), .ra(ra), .rb(rb),
    .v2(v2), .det(det), .num_x(num_x), .num_y(num_y),
    .side_a(side_a), .side_b(side_b), .len_a(len_a), .len_b(len_b),
    .s2_ax0(c2_ax0), .s2_ay0(c2_ay0), .s2_ax1(c2_ax1), .s2_ay1(c2_ay1),
    .s2_bx0(c2_bx0), .s2_by0(c2_by0), .s2_bx1(c2_bx1), .s2_by1(c2_by1),
    .mnx_a(mnx_a), .mxx_a(mxx_a), .mny_a(mny_a), .mxy_a(mxy_a),
    .mnx_b(mnx_b), .mxx_b(mxx_b), .mny_b(mny_b), .mxy_b(mxy_b)
  );

  segx_bound #(.COORD_BITS(COORD_BITS)) u_bound (
    .clk(clk), .rst(rst), .adv(adv), .v2(v2),
    .det(det), .num_x(num_x), .num_y(num_y),
    .side_a(side_a), .side_b(side_b), .len_a(len_a), .len_b(len_b),
    .ax0(c2_ax0), .ay0(c2_ay0), .ax1(c2_ax1), .ay1(c2_ay1),
    .bx0(c2_bx0), .by0(c2_by0), .bx1(c2_bx1), .by1(c2_by1),
    .mnx_a(mnx_a), .mxx_a(mxx_a), .mny_a(mny_a), .mxy_a(mxy_a),
    .mnx_b(mnx_b), .mxx_b(mxx_b), .mny_b(mny_b), .mxy_b(mxy_b),
    .v3(v3), .s3_x(s3_x), .s3_y(s3_y),
    .lox_a(lox_a), .hix_a(hix_a), .loy_a(loy_a), .hiy_a(hiy_a),
    .lox_b(lox_b), .hix_b(hix_b), .loy_b(loy_b), .hiy_b(hiy_b),
    .flat_xa(flat_xa), .flat_ya(flat_ya), .flat_xb(flat_xb), .flat_yb(flat_yb),
    .crossing(crossing), .col_hit(col_hit)
  );

  segx_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk(clk), .rst(rst), .adv(adv), .v3(v3),
    .num_x(s3_x), .num_y(s3_y),
    .lox_a(lox_a), .hix_a(hix_a), .loy_a(loy_a), .hiy_a(hiy_a),
    .lox_b(lox_b), .hix_b(hix_b), .loy_b(loy_b), .hiy_b(hiy_b),
    .flat_xa(flat_xa), .flat_ya(flat_ya), .flat_xb(flat_xb), .flat_yb(flat_yb),
    .crossing(crossing), .col_hit(col_hit),
    .v4(v4), .hit(hit)
  );

  // Input is refused only under real output backpressure
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !segs.ready |-> (res.valid && !res.ready))
    else $error("input stalled without output backpressure");

  // A stall freezes the inner stage valids
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3}))
    else $error("stage valid changed during stall");

  // A drained result with nothing behind it is not repeated
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !v3) |=> !res.valid)
    else $error("result beat repeated");
endmodule

>>> tb/tb_segment_intersection_test.sv
// Testbench for segment_intersection_test: directed and random segment pairs against a predictor.
`timescale 1ns / 1ps

module tb_segment_intersection_test;
  import segx_pkg::*;

  localparam int COORD_BITS   = COORD_BITS_DEF;
  localparam int NUM_DIR      = 24;
  localparam int RANDOM_ITEMS = 1276;
  localparam int CALM_TAIL    = 200;
  localparam int STUCK_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One input beat: both segments
  typedef struct {
    coord_t a_start_x, a_start_y, a_end_x, a_end_y;
    coord_t b_start_x, b_start_y, b_end_x, b_end_y;
  } seg_pair_t;

  // How a stimulus row is checked: by the predictor, or against a value known by hand
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_HIT,
    ROW_MISS
  } row_kind_e;

  typedef struct packed {
    int        ax0, ay0, ax1, ay1;
    int        bx0, by0, bx1, by1;
    row_kind_e kind;
  } dir_row_t;

  typedef struct {
    bit          intersects;
    int unsigned seq;
    seg_pair_t   pair;
  } flag_entry_t;

  logic clk;
  logic rst;

  segx_in_if #(.COORD_BITS(COORD_BITS)) segs_if ();
  segx_out_if                           res_if ();

  segment_intersection_test #(.COORD_BITS(COORD_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .segs (segs_if),
    .res  (res_if)
  );

  // Directed rows: corners, touching, parallel, collinear and point cases
  dir_row_t dir_rows [NUM_DIR] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, ROW_MISS},                         // all at origin
    '{-10, -10, 10, 10, -10, 10, 10, -10, ROW_HIT},              // plain X crossing
    '{-10, -10, 10, 10, 10, -10, -10, 10, ROW_HIT},              // B reversed, det flips sign
    '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, ROW_HIT},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, ROW_MISS},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, ROW_MISS},
    '{0, 0, 10, 0, 10, 0, 10, 10, ROW_MISS},                     // meet at a shared endpoint
    '{0, 0, 10, 0, 5, 0, 5, 10, ROW_MISS},                       // T junction on an endpoint
    '{0, 5, 10, 5, 5, 0, 5, 10, ROW_HIT},                        // axis-aligned plus
    '{0, 0, 10, 0, 11, -5, 11, 5, ROW_MISS},                     // crossing point past A
    '{0, 0, 10, 0, 0, 1, 10, 1, ROW_MISS},                       // parallel, offset
    '{0, 0, 10, 0, 5, 0, 15, 0, ROW_MODEL},                      // collinear overlap, equal lengths
    '{0, 0, 10, 0, 20, 0, 30, 0, ROW_MISS},                      // collinear, apart
    '{0, 0, 10, 0, 10, 0, 20, 0, ROW_MISS},                      // collinear, end to end
    '{0, 0, 10, 10, 2, 2, 4, 4, ROW_MODEL},                      // diagonal, B inside A
    '{0, 0, 10, 10, 0, 0, 10, 10, ROW_MODEL},                    // identical segments
    '{5, 5, 5, 5, 0, 0, 10, 10, ROW_MODEL},                      // point A on segment B
    '{5, 6, 5, 6, 0, 0, 10, 10, ROW_MISS},                       // point A off line B
    '{3, 3, 3, 3, 3, 3, 3, 3, ROW_MISS},                         // both points
    '{0, -32768, 0, 32767, 0, 0, 0, 100, ROW_MODEL},             // vertical, full range
    '{0, 0, 3, 1, 0, 1, 3, 0, ROW_MODEL},                        // crossing off the grid
    '{10, 10, -10, -10, -10, 10, 10, -10, ROW_MODEL},
    '{2, 0, 3, 0, -32768, 0, 32767, 0, ROW_MODEL},               // shorter A inside B
    '{-1, -1, -32768, 32767, 32767, -32768, -2, -3, ROW_MODEL}
  };

  int corner_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  flag_entry_t pending_flags [$];
  row_kind_e   row_tag;
  bit          idle_on = 1'b1;
  int          mismatch_count;
  int unsigned beat_seq;
  int          stuck_cycles;

  // Sign of a point against the line through two points
  function automatic int side_sign(input longint px, py, x0, y0, x1, y1);
    longint f;
    f = (y0 - y1) * px + (x1 - x0) * py + (y1 * x0 - y0 * x1);
    return (f > 0) ? 1 : ((f < 0) ? -1 : 0);
  endfunction

  // Scaled point (nx/den, ny/den) strictly inside the box of a segment; flat boxes use one axis
  function automatic bit strict_in_box(input longint nx, ny, den, x0, y0, x1, y1);
    longint mn_x, mx_x, mn_y, mx_y, lo_x, hi_x, lo_y, hi_y;
    bit     in_x, in_y;
    mn_x = (x0 < x1) ? x0 : x1;
    mx_x = (x0 > x1) ? x0 : x1;
    mn_y = (y0 < y1) ? y0 : y1;
    mx_y = (y0 > y1) ? y0 : y1;
    lo_x = den * ((den < 0) ? mx_x : mn_x);
    hi_x = den * ((den < 0) ? mn_x : mx_x);
    lo_y = den * ((den < 0) ? mx_y : mn_y);
    hi_y = den * ((den < 0) ? mn_y : mx_y);
    in_x = (nx > lo_x) && (nx < hi_x);
    in_y = (ny > lo_y) && (ny < hi_y);
    return ((lo_x == hi_x) && in_y) || ((lo_y == hi_y) && in_x) || (in_x && in_y);
  endfunction

  // Whether the two segments cross or overlap
  function automatic bit segments_cross(input seg_pair_t s);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint pa, qa, ra, pb, qb, rb, det, num_x, num_y, len_a, len_b;
    bit     hit;
    ax0 = s.a_start_x;
    ay0 = s.a_start_y;
    ax1 = s.a_end_x;
    ay1 = s.a_end_y;
    bx0 = s.b_start_x;
    by0 = s.b_start_y;
    bx1 = s.b_end_x;
    by1 = s.b_end_y;
    hit = 1'b0;
    pa  = ay0 - ay1;
    qa  = ax1 - ax0;
    ra  = ay1 * ax0 - ay0 * ax1;
    pb  = by0 - by1;
    qb  = bx1 - bx0;
    rb  = by1 * bx0 - by0 * bx1;
    det = pb * qa - pa * qb;
    if (det != 0) begin
      num_y = pa * rb - pb * ra;
      num_x = qb * ra - qa * rb;
      hit = strict_in_box(num_x, num_y, det, ax0, ay0, ax1, ay1) &&
            strict_in_box(num_x, num_y, det, bx0, by0, bx1, by1);
    end else if (side_sign(ax0, ay0, bx0, by0, bx1, by1) == 0 &&
                 side_sign(bx0, by0, ax0, ay0, ax1, ay1) == 0) begin
      // collinear: an endpoint of the shorter one strictly inside the longer
      len_a = qa * qa + pa * pa;
      len_b = qb * qb + pb * pb;
      if (len_a < len_b) begin
        hit = strict_in_box(ax0, ay0, 1, bx0, by0, bx1, by1) ||
              strict_in_box(ax1, ay1, 1, bx0, by0, bx1, by1);
      end else begin
        hit = strict_in_box(bx0, by0, 1, ax0, ay0, ax1, ay1) ||
              strict_in_box(bx1, by1, 1, ax0, ay0, ax1, ay1);
      end
    end
    return hit;
  endfunction

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic seg_pair_t pack_pair(input int v [8]);
    seg_pair_t s;
    s.a_start_x = COORD_BITS'(v[0]);
    s.a_start_y = COORD_BITS'(v[1]);
    s.a_end_x   = COORD_BITS'(v[2]);
    s.a_end_y   = COORD_BITS'(v[3]);
    s.b_start_x = COORD_BITS'(v[4]);
    s.b_start_y = COORD_BITS'(v[5]);
    s.b_end_x   = COORD_BITS'(v[6]);
    s.b_end_y   = COORD_BITS'(v[7]);
    return s;
  endfunction

  // Random pair: noise, small grids, collinear sets, shared points, corners, axis-aligned
  function automatic seg_pair_t random_pair();
    int v [8];
    int px, py, dx, dy, k, s, t;
    px = pick(-2000, 2000);
    py = pick(-2000, 2000);
    dx = pick(-40, 40);
    dy = pick(-40, 40);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int i = 0; i < 8; i++) v[i] = int'($urandom);
      end
      3, 4: begin
        for (int i = 0; i < 8; i++) v[i] = pick(-8, 8);
      end
      5, 6: begin
        // four points on one line
        for (int j = 0; j < 4; j++) begin
          t = pick(-12, 12);
          v[2*j]   = px + t * dx;
          v[2*j+1] = py + t * dy;
        end
      end
      7: begin
        // B starts on segment A, often at an endpoint
        k = pick(1, 12);
        s = pick(0, k);
        v[0] = px;
        v[1] = py;
        v[2] = px + k * dx;
        v[3] = py + k * dy;
        v[4] = px + s * dx;
        v[5] = py + s * dy;
        v[6] = pick(-3000, 3000);
        v[7] = pick(-3000, 3000);
      end
      8: begin
        for (int i = 0; i < 8; i++)
          v[i] = ($urandom_range(0, 3) != 0) ? corner_vals[pick(0, 6)] : int'($urandom);
      end
      default: begin
        // horizontal A, vertical B
        v[1] = pick(-20, 20);
        v[3] = v[1];
        v[0] = pick(-20, 20);
        v[2] = pick(-20, 20);
        v[4] = pick(-20, 20);
        v[6] = v[4];
        v[5] = pick(-20, 20);
        v[7] = pick(-20, 20);
      end
    endcase
    return pack_pair(v);
  endfunction

  task automatic report_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Drive one beat, with an optional gap before it, and wait until it is taken
  task automatic send_pair(input seg_pair_t s, input row_kind_e kind);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      segs_if.valid <= 1'b0;
      repeat (pick(1, 8)) @(posedge clk);
    end
    segs_if.valid     <= 1'b1;
    segs_if.a_start_x <= s.a_start_x;
    segs_if.a_start_y <= s.a_start_y;
    segs_if.a_end_x   <= s.a_end_x;
    segs_if.a_end_y   <= s.a_end_y;
    segs_if.b_start_x <= s.b_start_x;
    segs_if.b_start_y <= s.b_start_y;
    segs_if.b_end_x   <= s.b_end_x;
    segs_if.b_end_y   <= s.b_end_y;
    row_tag           <= kind;
    do @(posedge clk); while (!segs_if.ready);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops in random bursts while idling is on
  initial begin : res_stall
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = pick(1, 8) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Check result beats, then queue the prediction for a newly accepted input beat
  always @(posedge clk) begin : flag_check
    flag_entry_t e;
    seg_pair_t   p;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_flags.size() == 0) begin
          report_fault($sformatf("result beat with nothing pending, intersects=%0b",
                                 res_if.intersects));
        end else begin
          e = pending_flags.pop_front();
          if (res_if.intersects !== e.intersects)
            report_fault($sformatf(
              "beat %0d A(%0d,%0d)-(%0d,%0d) B(%0d,%0d)-(%0d,%0d): intersects exp %0b got %0b",
              e.seq, e.pair.a_start_x, e.pair.a_start_y, e.pair.a_end_x, e.pair.a_end_y,
              e.pair.b_start_x, e.pair.b_start_y, e.pair.b_end_x, e.pair.b_end_y,
              e.intersects, res_if.intersects));
        end
      end
      if (segs_if.valid && segs_if.ready) begin
        p.a_start_x = segs_if.a_start_x;
        p.a_start_y = segs_if.a_start_y;
        p.a_end_x   = segs_if.a_end_x;
        p.a_end_y   = segs_if.a_end_y;
        p.b_start_x = segs_if.b_start_x;
        p.b_start_y = segs_if.b_start_y;
        p.b_end_x   = segs_if.b_end_x;
        p.b_end_y   = segs_if.b_end_y;
        e.pair = p;
        e.seq  = beat_seq;
        case (row_tag)
          ROW_HIT:  e.intersects = 1'b1;
          ROW_MISS: e.intersects = 1'b0;
          default:  e.intersects = segments_cross(p);
        endcase
        pending_flags.push_back(e);
        beat_seq++;
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  initial begin
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (segs_if.valid && segs_if.ready) || (res_if.valid && res_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int v [8];
    seg_pair_t s;
    mismatch_count = 0;
    beat_seq       = 0;
    rst               <= 1'b1;
    row_tag           <= ROW_MODEL;
    segs_if.valid     <= 1'b0;
    segs_if.a_start_x <= '0;
    segs_if.a_start_y <= '0;
    segs_if.a_end_x   <= '0;
    segs_if.a_end_y   <= '0;
    segs_if.b_start_x <= '0;
    segs_if.b_start_y <= '0;
    segs_if.b_end_x   <= '0;
    segs_if.b_end_y   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < NUM_DIR; i++) begin
      v = '{dir_rows[i].ax0, dir_rows[i].ay0, dir_rows[i].ax1, dir_rows[i].ay1,
            dir_rows[i].bx0, dir_rows[i].by0, dir_rows[i].bx1, dir_rows[i].by1};
      send_pair(pack_pair(v), dir_rows[i].kind);
    end

    // random pairs; idling is redrawn per block of 100 and stops for the tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_TAIL)
        idle_on = 1'b0;
      else if (i % 100 == 0 && i < RANDOM_ITEMS - CALM_TAIL)
        idle_on = ($urandom_range(0, 3) != 0);
      s = random_pair();
      send_pair(s, ROW_MODEL);
    end
    segs_if.valid <= 1'b0;

    // drain, then allow for the pipeline depth
    @(posedge clk);
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
